/* src/tps_pkg.sv */
// shared types, constants and helpers for the transport packet segmenter
package tps_pkg;

   localparam int STREAM_SLOTS = 3;
   localparam int SLOT_W       = (STREAM_SLOTS > 1) ? $clog2(STREAM_SLOTS) : 1;

   localparam int JOB_BYTES = 8;
   localparam int JOB_IDX_W = $clog2(JOB_BYTES);

   localparam logic [10:0] MTU_RESET = 11'd23;
   localparam logic [10:0] MTU_MIN   = 11'd8;
   localparam logic [10:0] MTU_MAX   = 11'd1024;

   localparam logic [10:0] HDR_FIRST = 11'd6;
   localparam logic [10:0] HDR_NEXT  = 11'd3;

   localparam logic [1:0] TYPE_INITIAL  = 2'd0;
   localparam logic [1:0] TYPE_CONTINUE = 2'd1;
   localparam logic [1:0] TYPE_FINAL    = 2'd2;

   localparam logic [3:0] TXN_RESET = 4'hf;

   localparam logic [3:0] STREAM_CONTROL = 4'd0;
   localparam logic [3:0] STREAM_OTA     = 4'd2;
   localparam logic [3:0] STREAM_VOICE   = 4'd6;

   localparam logic [1:0] SLOT_NONE = 2'd3;

   // one queued job: the bytes one request produces, oldest first
   typedef struct packed {
      logic [JOB_BYTES-1:0][7:0] bytes;
      logic [JOB_IDX_W-1:0]      last_idx;
      logic                      pend;
      logic                      tend;
      logic                      bad;
   } job_type;

   function automatic logic [1:0] stream_code(input logic [3:0] stream);
      logic [1:0] code;
      case (stream)
         STREAM_CONTROL: code = 2'd0;
         STREAM_OTA:     code = 2'd1;
         STREAM_VOICE:   code = 2'd2;
         default:        code = SLOT_NONE;
      endcase
      return code;
   endfunction

endpackage

/* src/transport_packet_segmenter.sv */
// top level of the transport packet segmenter
//
//  channel  | direction | handshake             | payload
//  req_     | in        | req_push / req_full   | payload byte, start, stream, ack, length
//  rsp_     | out       | rsp_pop / rsp_empty   | byte, run/packet/transaction end, bad stream
//  csr_     | in        | csr_valid / csr_ready | link_mtu (always ready)
//
// the back end delivers one result byte per cycle while rsp_pop is high, so a request yields:
// one byte for a plain payload byte, up to eight when it opens a packet with its header
// throughput is set by that byte sequencer; a two-entry job queue lets the front keep
// taking requests while the back end waits on rsp_pop
// requests that produce no bytes are not queued and cost nothing downstream
// synchronous active-high reset; no clearing pass, ready the cycle after reset
module transport_packet_segmenter (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [10:0] csr_link_mtu,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_payload_byte,
   input  logic        req_starts_transaction,
   input  logic [3:0]  req_stream_id,
   input  logic        req_ack_request,
   input  logic [15:0] req_total_length,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_run_last,
   output logic        rsp_packet_end,
   output logic        rsp_transaction_end,
   output logic        rsp_bad_stream
);

   tps_pkg::job_type push_job;
   tps_pkg::job_type head;
   logic             q_push;
   logic             q_pop;
   logic             q_full;
   logic             q_empty;

   assign csr_ready = 1'b1;
   assign req_full  = q_full;

   tps_front u_front (
      .clock                  (clock),
      .reset                  (reset),
      .csr_valid              (csr_valid),
      .csr_link_mtu           (csr_link_mtu),
      .req_push               (req_push),
      .req_payload_byte       (req_payload_byte),
      .req_starts_transaction (req_starts_transaction),
      .req_stream_id          (req_stream_id),
      .req_ack_request        (req_ack_request),
      .req_total_length       (req_total_length),
      .q_full                 (q_full),
      .q_push                 (q_push),
      .q_job                  (push_job)
   );

   tps_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .full     (q_full),
      .empty    (q_empty),
      .head     (head)
   );

   tps_back u_back (
      .clock               (clock),
      .reset               (reset),
      .head                (head),
      .q_empty             (q_empty),
      .q_pop               (q_pop),
      .rsp_pop             (rsp_pop),
      .rsp_empty           (rsp_empty),
      .rsp_out_byte        (rsp_out_byte),
      .rsp_run_last        (rsp_run_last),
      .rsp_packet_end      (rsp_packet_end),
      .rsp_transaction_end (rsp_transaction_end),
      .rsp_bad_stream      (rsp_bad_stream)
   );

endmodule

/* src/tps_front.sv */
// front end: takes requests, tracks transaction state, builds byte jobs
module tps_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   input  logic [10:0]        csr_link_mtu,
   input  logic               req_push,
   input  logic [7:0]         req_payload_byte,
   input  logic               req_starts_transaction,
   input  logic [3:0]         req_stream_id,
   input  logic               req_ack_request,
   input  logic [15:0]        req_total_length,
   input  logic               q_full,
   output logic               q_push,
   output tps_pkg::job_type   q_job
);

   logic [10:0] mtu_ff, mtu_in;
   logic [3:0]  last_txn_ff [tps_pkg::STREAM_SLOTS];
   logic [3:0]  last_txn_in [tps_pkg::STREAM_SLOTS];
   logic [15:0] br_ff, br_in;
   logic [9:0]  pbl_ff, pbl_in;
   logic [3:0]  seq_ff, seq_in;
   logic [3:0]  txn_ff, txn_in;
   logic [3:0]  stream_ff, stream_in;
   logic        ack_ff, ack_in;
   logic        dropping_ff, dropping_in;

   logic                        accept;
   logic [1:0]                  code;
   logic                        valid_stream;
   logic [tps_pkg::SLOT_W-1:0]  slot;
   logic                        first;
   logic                        active;
   logic                        bad_start;
   logic [15:0]                 br_eff;
   logic [9:0]                  pbl_eff;
   logic [3:0]                  seq_eff;
   logic [3:0]                  txn_next;
   logic [3:0]                  txn_eff;
   logic [3:0]                  stream_eff;
   logic                        ack_eff;
   logic                        need_hdr;
   logic [10:0]                 mtu_c;
   logic [10:0]                 room;
   logic [10:0]                 pay_a;
   logic [10:0]                 pay_b;
   logic                        ext;
   logic [1:0]                  ptype;
   logic [9:0]                  pkt_len;
   logic [9:0]                  pbl_dec;
   logic [15:0]                 br_dec;
   logic                        pend;
   logic                        tend;
   logic [tps_pkg::JOB_IDX_W-1:0] pos;

   assign accept       = req_push & ~q_full;
   assign code         = tps_pkg::stream_code(req_stream_id);
   assign valid_stream = (code != tps_pkg::SLOT_NONE) &&
                         (int'(code) < tps_pkg::STREAM_SLOTS);
   assign slot         = tps_pkg::SLOT_W'(code);
   assign first        = req_starts_transaction & valid_stream & (req_total_length != 16'd0);
   assign bad_start    = req_starts_transaction & ~valid_stream;
   assign active       = req_starts_transaction ? first
                                                : (~dropping_ff & (br_ff != 16'd0));

   assign br_eff     = req_starts_transaction ? req_total_length : br_ff;
   assign pbl_eff    = req_starts_transaction ? 10'd0 : pbl_ff;
   assign seq_eff    = req_starts_transaction ? 4'd0 : seq_ff;
   assign txn_next   = last_txn_ff[slot] + 4'd1;
   assign txn_eff    = req_starts_transaction ? txn_next : txn_ff;
   assign stream_eff = req_starts_transaction ? req_stream_id : stream_ff;
   assign ack_eff    = req_starts_transaction ? req_ack_request : ack_ff;
   assign need_hdr   = (pbl_eff == 10'd0);

   // packet sizing
   always_comb begin
      if (mtu_ff < tps_pkg::MTU_MIN) begin
         mtu_c = tps_pkg::MTU_MIN;
      end else if (mtu_ff > tps_pkg::MTU_MAX) begin
         mtu_c = tps_pkg::MTU_MAX;
      end else begin
         mtu_c = mtu_ff;
      end
      room  = mtu_c - (first ? tps_pkg::HDR_FIRST : tps_pkg::HDR_NEXT);
      pay_a = ({5'd0, room} > br_eff) ? br_eff[10:0] : room;
      ext   = (pay_a > 11'd255);
      // extended length byte steals one payload byte when the packet is full
      pay_b = (ext && (pay_a > (room - 11'd1))) ? (pay_a - 11'd1) : pay_a;
      if (first) begin
         ptype = tps_pkg::TYPE_INITIAL;
      end else if ({5'd0, pay_b} == br_eff) begin
         ptype = tps_pkg::TYPE_FINAL;
      end else begin
         ptype = tps_pkg::TYPE_CONTINUE;
      end
   end

   assign pkt_len = need_hdr ? pay_b[9:0] : pbl_eff;
   assign pbl_dec = pkt_len - 10'd1;
   assign br_dec  = br_eff - 16'd1;
   assign pend    = (pbl_dec == 10'd0);
   assign tend    = (br_dec == 16'd0);

   // job assembly
   always_comb begin
      q_job = '0;
      pos   = '0;
      if (bad_start) begin
         q_job.bad = 1'b1;
      end else begin
         if (need_hdr) begin
            q_job.bytes[pos] = {stream_eff, txn_eff};
            pos = pos + 1'b1;
            q_job.bytes[pos] = {seq_eff, ptype, ack_eff, ext};
            pos = pos + 1'b1;
            if (first) begin
               q_job.bytes[pos] = 8'd0;
               pos = pos + 1'b1;
               q_job.bytes[pos] = req_total_length[15:8];
               pos = pos + 1'b1;
               q_job.bytes[pos] = req_total_length[7:0];
               pos = pos + 1'b1;
            end
            if (ext) begin
               q_job.bytes[pos] = {5'd0, pay_b[10:8]};
               pos = pos + 1'b1;
            end
            q_job.bytes[pos] = pay_b[7:0];
            pos = pos + 1'b1;
         end
         q_job.bytes[pos] = req_payload_byte;
         q_job.last_idx   = pos;
         q_job.pend       = pend;
         q_job.tend       = tend;
      end
   end

   assign q_push = accept & (bad_start | active);

   // next state
   always_comb begin
      mtu_in      = csr_valid ? csr_link_mtu : mtu_ff;
      last_txn_in = last_txn_ff;
      br_in       = br_ff;
      pbl_in      = pbl_ff;
      seq_in      = seq_ff;
      txn_in      = txn_ff;
      stream_in   = stream_ff;
      ack_in      = ack_ff;
      dropping_in = dropping_ff;
      if (accept) begin
         if (req_starts_transaction) begin
            dropping_in = ~valid_stream;
            br_in       = 16'd0;
            pbl_in      = 10'd0;
            seq_in      = 4'd0;
         end
         if (active) begin
            br_in  = br_dec;
            pbl_in = tend ? 10'd0 : pbl_dec;
            seq_in = need_hdr ? (seq_eff + 4'd1) : seq_eff;
            if (first) begin
               last_txn_in[slot] = txn_next;
               txn_in            = txn_next;
               stream_in         = req_stream_id;
               ack_in            = req_ack_request;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mtu_ff      <= tps_pkg::MTU_RESET;
         br_ff       <= '0;
         pbl_ff      <= '0;
         seq_ff      <= '0;
         txn_ff      <= '0;
         stream_ff   <= '0;
         ack_ff      <= 1'b0;
         dropping_ff <= 1'b0;
         for (int i = 0; i < tps_pkg::STREAM_SLOTS; i++) begin
            last_txn_ff[i] <= tps_pkg::TXN_RESET;
         end
      end else begin
         mtu_ff      <= mtu_in;
         br_ff       <= br_in;
         pbl_ff      <= pbl_in;
         seq_ff      <= seq_in;
         txn_ff      <= txn_in;
         stream_ff   <= stream_in;
         ack_ff      <= ack_in;
         dropping_ff <= dropping_in;
         last_txn_ff <= last_txn_in;
      end
   end

endmodule

/* src/tps_queue.sv */
// two-entry job queue between front and back, head always in entry zero
module tps_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  tps_pkg::job_type push_job,
   input  logic             pop,
   output logic             full,
   output logic             empty,
   output tps_pkg::job_type head
);

   tps_pkg::job_type s0_ff, s0_in;
   tps_pkg::job_type s1_ff, s1_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push;
   logic             do_pop;
   logic [1:0]       wpos;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign head    = s0_ff;
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign wpos    = count_ff - {1'b0, do_pop};

   always_comb begin
      s0_in    = s0_ff;
      s1_in    = s1_ff;
      count_in = count_ff + {1'b0, do_push} - {1'b0, do_pop};
      if (do_pop) begin
         s0_in = s1_ff;
      end
      if (do_push && wpos == 2'd0) begin
         s0_in = push_job;
      end
      if (do_push && wpos == 2'd1) begin
         s1_in = push_job;
      end
   end

   always_ff @(posedge clock) begin
      s0_ff <= s0_in;
      s1_ff <= s1_in;
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

/* src/tps_back.sv */
// back end: walks the bytes of the head job onto the response port
module tps_back (
   input  logic             clock,
   input  logic             reset,
   input  tps_pkg::job_type head,
   input  logic             q_empty,
   output logic             q_pop,
   input  logic             rsp_pop,
   output logic             rsp_empty,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_run_last,
   output logic             rsp_packet_end,
   output logic             rsp_transaction_end,
   output logic             rsp_bad_stream
);

   logic [tps_pkg::JOB_IDX_W-1:0] idx_ff, idx_in;
   logic                          last;
   logic                          take;

   assign last = (idx_ff == head.last_idx);
   assign take = rsp_pop & ~q_empty;

   assign rsp_empty           = q_empty;
   assign rsp_out_byte        = head.bytes[idx_ff];
   assign rsp_run_last        = last;
   assign rsp_packet_end      = last & head.pend;
   assign rsp_transaction_end = last & head.tend;
   assign rsp_bad_stream      = head.bad;
   assign q_pop               = take & last;

   always_comb begin
      idx_in = idx_ff;
      if (take) begin
         idx_in = last ? '0 : (idx_ff + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

/* verif/testbench.sv */
// self-checking testbench for the transport packet segmenter: directed cases, then random phases
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       packet_end;
      logic       transaction_end;
      logic       bad_stream;
   } seg_byte_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_valid;
   logic        csr_ready;
   logic [10:0] csr_link_mtu;
   logic        req_push;
   logic        req_full;
   logic [7:0]  req_payload_byte;
   logic        req_starts_transaction;
   logic [3:0]  req_stream_id;
   logic        req_ack_request;
   logic [15:0] req_total_length;
   logic        rsp_empty;
   logic        rsp_pop;
   logic [7:0]  rsp_out_byte;
   logic        rsp_run_last;
   logic        rsp_packet_end;
   logic        rsp_transaction_end;
   logic        rsp_bad_stream;

   seg_byte_type segment_bytes_due[$];
   int          fail_count = 0;
   int          idle_pct = 0;
   int          stall_pct = 0;
   int          counted_items = 0;

   // predictor copy of the segmenter state
   logic [10:0] mtu_now;
   logic [3:0]  txn_by_slot [tps_pkg::STREAM_SLOTS];
   int          txn_bytes_left;
   int          pkt_bytes_left;
   logic [3:0]  seq_num;
   logic [3:0]  open_txn;
   logic [3:0]  open_stream;
   logic        open_ack;
   logic        drop_mode;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   transport_packet_segmenter i_dut (
      .clock                  (clock),
      .reset                  (reset),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_link_mtu           (csr_link_mtu),
      .req_push               (req_push),
      .req_full               (req_full),
      .req_payload_byte       (req_payload_byte),
      .req_starts_transaction (req_starts_transaction),
      .req_stream_id          (req_stream_id),
      .req_ack_request        (req_ack_request),
      .req_total_length       (req_total_length),
      .rsp_empty              (rsp_empty),
      .rsp_pop                (rsp_pop),
      .rsp_out_byte           (rsp_out_byte),
      .rsp_run_last           (rsp_run_last),
      .rsp_packet_end         (rsp_packet_end),
      .rsp_transaction_end    (rsp_transaction_end),
      .rsp_bad_stream         (rsp_bad_stream)
   );

   task automatic report_mismatch(input string what, input int got, input int want);
      fail_count++;
      $display("error at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
   endtask

   function automatic int slot_of(input logic [3:0] stream);
      case (stream)
         tps_pkg::STREAM_CONTROL: return 0;
         tps_pkg::STREAM_OTA:     return 1;
         tps_pkg::STREAM_VOICE:   return 2;
         default:                 return -1;
      endcase
   endfunction

   function automatic void add_byte(input logic [7:0] data, input logic pend,
                                    input logic tend, input logic bad);
      seg_byte_type r;
      r.out_byte        = data;
      r.run_last        = 1'b0;
      r.packet_end      = pend;
      r.transaction_end = tend;
      r.bad_stream      = bad;
      segment_bytes_due.push_back(r);
   endfunction

   // flag the newest byte as the last one of its request
   function automatic void close_run();
      seg_byte_type r;
      r = segment_bytes_due.pop_back();
      r.run_last = 1'b1;
      segment_bytes_due.push_back(r);
   endfunction

   // returns 1 when the request changes anything, 0 when the block ignores it
   function automatic bit segment_request(input logic [7:0] data, input logic start,
                                          input logic [3:0] stream, input logic ack,
                                          input logic [15:0] total);
      int         slot;
      int         mtu;
      int         hdr;
      int         pay;
      bit         first;
      bit         ext;
      logic [1:0] ptype;
      first = 1'b0;
      if (start) begin
         slot = slot_of(stream);
         drop_mode      = 1'b0;
         txn_bytes_left = 0;
         pkt_bytes_left = 0;
         seq_num        = 4'd0;
         if (slot < 0 || slot >= tps_pkg::STREAM_SLOTS) begin
            drop_mode = 1'b1;
            add_byte(8'h00, 1'b0, 1'b0, 1'b1);
            close_run();
            return 1'b1;
         end
         if (total == 16'd0) return 1'b1;
         txn_by_slot[slot] = txn_by_slot[slot] + 4'd1;
         open_txn       = txn_by_slot[slot];
         open_stream    = stream;
         open_ack       = ack;
         txn_bytes_left = total;
         first          = 1'b1;
      end else if (drop_mode || txn_bytes_left == 0) begin
         return 1'b0;
      end
      if (pkt_bytes_left == 0) begin
         mtu = mtu_now;
         if (mtu < tps_pkg::MTU_MIN) mtu = tps_pkg::MTU_MIN;
         if (mtu > tps_pkg::MTU_MAX) mtu = tps_pkg::MTU_MAX;
         hdr = first ? tps_pkg::HDR_FIRST : tps_pkg::HDR_NEXT;
         pay = mtu - hdr;
         if (pay > txn_bytes_left) pay = txn_bytes_left;
         ext = (pay > 255);
         if (ext) begin
            hdr++;
            if (pay > mtu - hdr) pay--;
         end
         if (first) ptype = tps_pkg::TYPE_INITIAL;
         else if (pay == txn_bytes_left) ptype = tps_pkg::TYPE_FINAL;
         else ptype = tps_pkg::TYPE_CONTINUE;
         add_byte({open_stream, open_txn}, 1'b0, 1'b0, 1'b0);
         add_byte({seq_num, ptype, open_ack, ext}, 1'b0, 1'b0, 1'b0);
         seq_num = seq_num + 4'd1;
         if (first) begin
            add_byte(8'h00, 1'b0, 1'b0, 1'b0);
            add_byte(total[15:8], 1'b0, 1'b0, 1'b0);
            add_byte(total[7:0], 1'b0, 1'b0, 1'b0);
         end
         if (ext) add_byte(8'(pay >> 8), 1'b0, 1'b0, 1'b0);
         add_byte(8'(pay), 1'b0, 1'b0, 1'b0);
         pkt_bytes_left = pay;
      end
      pkt_bytes_left--;
      txn_bytes_left--;
      add_byte(data, pkt_bytes_left == 0, txn_bytes_left == 0, 1'b0);
      if (txn_bytes_left == 0) pkt_bytes_left = 0;
      close_run();
      return 1'b1;
   endfunction

   // called and returns at a falling edge; leaves req_push high for the next request
   task automatic send_request(input logic [7:0] data, input logic start,
                               input logic [3:0] stream, input logic ack,
                               input logic [15:0] total);
      if ($urandom_range(99) < idle_pct) begin
         req_push <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_payload_byte       <= data;
      req_starts_transaction <= start;
      req_stream_id          <= stream;
      req_ack_request        <= ack;
      req_total_length       <= total;
      req_push               <= 1'b1;
      do @(posedge clock); while (req_full);
      @(negedge clock);
      counted_items += segment_request(data, start, stream, ack, total);
   endtask

   task automatic send_noise_byte();
      send_request(8'($urandom), 1'b0, 4'($urandom), 1'($urandom), 16'($urandom));
   endtask

   // stop sending, wait for every due byte, then let any zero-result work settle
   task automatic wait_for_drain();
      req_push <= 1'b0;
      for (int k = 0; k < 100000 && segment_bytes_due.size() != 0; k++) @(negedge clock);
      repeat (32) @(negedge clock);
   endtask

   task automatic write_link_mtu(input logic [10:0] mtu);
      wait_for_drain();
      csr_valid    <= 1'b1;
      csr_link_mtu <= mtu;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      mtu_now = mtu;
   endtask

   task automatic send_random_transaction();
      logic [3:0]  stream;
      logic [15:0] total;
      int          sel;
      int          count;
      if ($urandom_range(99) < 80) begin
         case ($urandom_range(2))
            0:       stream = tps_pkg::STREAM_CONTROL;
            1:       stream = tps_pkg::STREAM_OTA;
            default: stream = tps_pkg::STREAM_VOICE;
         endcase
      end else begin
         stream = 4'($urandom_range(15));
      end
      sel = $urandom_range(99);
      if (sel < 55) total = 16'($urandom_range(1, 12));
      else if (sel < 80) total = 16'($urandom_range(13, 40));
      else if (sel < 96) total = 16'($urandom_range(65535));
      else total = 16'd0;
      // long transactions are only opened, a few bytes in
      if (total > 40) count = $urandom_range(1, 6);
      else count = total;
      sel = $urandom_range(99);
      if (sel < 10 && count > 1) count = $urandom_range(1, count - 1);
      else if (sel < 20) count++;
      if (slot_of(stream) < 0) count = $urandom_range(0, 3);
      if ($urandom_range(99) < 5) send_noise_byte();
      send_request(8'($urandom), 1'b1, stream, 1'($urandom), total);
      repeat (count - 1) send_noise_byte();
   endtask

   task automatic test_reset_mtu_basics();
      idle_pct  = 0;
      stall_pct = 0;
      // byte with no transaction open
      send_request(8'hff, 1'b0, 4'hf, 1'b1, 16'hffff);
      // single packet transaction stays initial
      send_request(8'h00, 1'b1, tps_pkg::STREAM_CONTROL, 1'b0, 16'd1);
      send_request(8'hff, 1'b1, tps_pkg::STREAM_OTA, 1'b1, 16'd3);
      send_request(8'h55, 1'b0, 4'h0, 1'b0, 16'h0000);
      send_request(8'haa, 1'b0, 4'h6, 1'b1, 16'h0001);
      // invalid streams, following bytes dropped
      send_request(8'h12, 1'b1, 4'd5, 1'b1, 16'd4);
      send_request(8'h34, 1'b0, 4'd0, 1'b0, 16'd4);
      send_request(8'h56, 1'b0, 4'd2, 1'b1, 16'd4);
      send_request(8'h78, 1'b1, 4'hf, 1'b0, 16'd2);
      // zero length goes idle, next byte ignored
      send_request(8'h9a, 1'b1, tps_pkg::STREAM_VOICE, 1'b1, 16'd0);
      send_request(8'hbc, 1'b0, 4'h6, 1'b1, 16'd5);
      // new start abandons an open transaction
      send_request(8'h01, 1'b1, tps_pkg::STREAM_CONTROL, 1'b1, 16'hffff);
      send_request(8'h02, 1'b0, 4'h0, 1'b1, 16'hffff);
      send_request(8'h03, 1'b0, 4'h0, 1'b1, 16'hffff);
      send_request(8'h04, 1'b1, tps_pkg::STREAM_CONTROL, 1'b0, 16'd2);
      send_request(8'h05, 1'b0, 4'h0, 1'b0, 16'd2);
   endtask

   task automatic test_multi_packet();
      write_link_mtu(tps_pkg::MTU_MIN);
      // initial, continue and final packets at the smallest mtu
      send_request(8'h10, 1'b1, tps_pkg::STREAM_VOICE, 1'b1, 16'd9);
      for (int k = 1; k < 9; k++) send_request(8'(8'h10 + k), 1'b0, 4'h6, 1'b1, 16'd9);
   endtask

   task automatic test_random_segments(input logic [10:0] mtu, input int sender_idle,
                                       input int receiver_stall, input int items,
                                       input bit pause_midway);
      bit paused;
      paused = 1'b0;
      write_link_mtu(mtu);
      idle_pct      = sender_idle;
      stall_pct     = receiver_stall;
      counted_items = 0;
      while (counted_items < items) begin
         send_random_transaction();
         if (pause_midway && !paused && counted_items >= items / 2) begin
            paused = 1'b1;
            wait_for_drain();
         end
      end
   endtask

   always @(negedge clock) rsp_pop <= ($urandom_range(99) >= stall_pct);

   always @(posedge clock) begin : result_check
      seg_byte_type want;
      if (!reset && !rsp_empty && rsp_pop) begin
         if (segment_bytes_due.size() == 0) begin
            report_mismatch("result with no request outstanding, out_byte", rsp_out_byte, 0);
         end else begin
            want = segment_bytes_due.pop_front();
            if (rsp_out_byte !== want.out_byte)
               report_mismatch("out_byte", rsp_out_byte, want.out_byte);
            if (rsp_run_last !== want.run_last)
               report_mismatch("run_last", rsp_run_last, want.run_last);
            if (rsp_packet_end !== want.packet_end)
               report_mismatch("packet_end", rsp_packet_end, want.packet_end);
            if (rsp_transaction_end !== want.transaction_end)
               report_mismatch("transaction_end", rsp_transaction_end, want.transaction_end);
            if (rsp_bad_stream !== want.bad_stream)
               report_mismatch("bad_stream", rsp_bad_stream, want.bad_stream);
         end
      end
   end

   initial begin
      reset                  = 1'b1;
      csr_valid              = 1'b0;
      csr_link_mtu           = 11'd0;
      req_push               = 1'b0;
      req_payload_byte       = 8'd0;
      req_starts_transaction = 1'b0;
      req_stream_id          = 4'd0;
      req_ack_request        = 1'b0;
      req_total_length       = 16'd0;
      rsp_pop                = 1'b0;
      mtu_now                = tps_pkg::MTU_RESET;
      for (int k = 0; k < tps_pkg::STREAM_SLOTS; k++) txn_by_slot[k] = tps_pkg::TXN_RESET;
      txn_bytes_left = 0;
      pkt_bytes_left = 0;
      seq_num        = 4'd0;
      open_txn       = 4'd0;
      open_stream    = 4'd0;
      open_ack       = 1'b0;
      drop_mode      = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_mtu_basics();
      test_multi_packet();
      test_random_segments(11'd262, 0, 0, 25, 1'b0);
      test_random_segments(tps_pkg::MTU_MIN, 54, 0, 25, 1'b0);
      test_random_segments(tps_pkg::MTU_MAX, 0, 54, 25, 1'b0);
      test_random_segments(11'd0, 36, 36, 25, 1'b0);
      test_random_segments(11'd2047, 0, 0, 25, 1'b1);
      test_random_segments(11'd7, 54, 0, 25, 1'b0);
      test_random_segments(11'd1025, 0, 54, 25, 1'b0);
      test_random_segments(11'($urandom_range(8, 1024)), 36, 36, 25, 1'b0);

      wait_for_drain();
      if (segment_bytes_due.size() != 0)
         report_mismatch("bytes never delivered, count", segment_bytes_due.size(), 0);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("FAILURE");
      $finish;
   end

endmodule

/* transport_packet_segmenter.f */
src/tps_pkg.sv
src/tps_front.sv
src/tps_queue.sv
src/tps_back.sv
src/transport_packet_segmenter.sv
verif/testbench.sv
